/* sv/ep26_pkg.sv */
`timescale 1ns / 1ps
// ep26_pkg: shared types and constants for the endpoint to base-26 letter block
// no dependencies

package ep26_pkg;

   // digit bound and derived widths
   localparam int MAX_DIGITS  = 11;
   localparam int DIGIT_W     = 5;
   localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W       = $clog2(MAX_DIGITS);

   // packed value split into 16-bit chunks for the long division
   localparam int VALUE_W     = 48;
   localparam int CHUNK_W     = 16;
   localparam int NUM_CHUNKS  = VALUE_W / CHUNK_W;
   localparam int CHUNK_IDX_W = 2;

   // divide by 26 via reciprocal: q = (x * RECIP) >> RECIP_SHIFT, exact for x < 26 * 2^16
   localparam int RADIX       = 26;
   localparam int DIV_IN_W    = DIGIT_W + CHUNK_W;
   localparam int RECIP_W     = 22;
   localparam int RECIP_SHIFT = 26;
   localparam logic [RECIP_W-1:0] RECIP = 22'd2581111;

   localparam logic [6:0] LETTER_BASE = 7'd65;

   typedef struct packed {
      logic [7:0]  octet_a;
      logic [7:0]  octet_b;
      logic [7:0]  octet_c;
      logic [7:0]  octet_d;
      logic [15:0] port_number;
   } req_type;

   typedef struct packed {
      logic [6:0] letter;
      logic       last_letter;
   } rsp_type;

endpackage

/* sv/endpoint_to_base26_letters.sv */
`timescale 1ns / 1ps
// endpoint_to_base26_letters: top level, sequencer, digit store and letter output
// depends on ep26_pkg and ep26_div_step
//
// Usage
//   Input: drive req_data and raise start; the item is taken on a rising edge
//   with start high and busy low. busy stays high until the last letter is out.
//   The four octets and the port form one 48-bit value, octets high, port low.
//   Output: one base-26 digit per cycle as an ASCII letter 'A'..'Z' on
//   rsp_data.letter, most significant first, each shown for exactly one cycle
//   with rsp_strobe high. rsp_data.last_letter marks the final letter. A zero
//   value gives the single letter 'A'. At most 11 letters per item.
//   Timing: one shared divide-by-26 unit works on one 16-bit chunk per cycle,
//   so each digit takes one pass over the three chunks; then the letters leave
//   one per cycle. The next item may be taken in the cycle after the last letter.
//   Reset (synchronous, active high) returns the sequencer to idle and holds
//   busy high while asserted; no clearing pass is needed.
//   The receiver cannot stall: every strobed letter must be taken as shown.

module endpoint_to_base26_letters (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ep26_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ep26_pkg::rsp_type rsp_data
);
   import ep26_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam logic [CHUNK_IDX_W-1:0] TOP_CHUNK = CHUNK_IDX_W'(NUM_CHUNKS - 1);

   logic [1:0]             st_ff, st_in;
   logic [VALUE_W-1:0]     value_ff, value_in;
   logic [CHUNK_IDX_W-1:0] chunk_ff, chunk_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COUNT_W-1:0]     emit_idx_ff, emit_idx_in;
   logic [DIGIT_W-1:0]     store_ff [MAX_DIGITS];

   logic                   accept;
   logic [CHUNK_W-1:0]     cur_chunk;
   logic [CHUNK_W-1:0]     step_quot;
   logic [DIGIT_W-1:0]     step_rem;
   logic                   digit_done;
   logic                   value_zero;
   logic [DIGIT_W-1:0]     emit_digit;

   assign accept = start && !busy;
   assign busy   = reset || (st_ff != ST_IDLE);

   // chunk under division, most significant first
   always_comb begin
      case (chunk_ff)
         2'd2:    cur_chunk = value_ff[3*CHUNK_W-1:2*CHUNK_W];
         2'd1:    cur_chunk = value_ff[2*CHUNK_W-1:CHUNK_W];
         default: cur_chunk = value_ff[CHUNK_W-1:0];
      endcase
   end

   // shared divide-by-26 unit
   ep26_div_step u_div (
      .rem_in   (rem_ff),
      .chunk_in (cur_chunk),
      .quot_out (step_quot),
      .rem_out  (step_rem)
   );

   // a digit is finished on the low chunk; quotient zero ends extraction
   assign digit_done = (st_ff == ST_DIV) && (chunk_ff == '0);
   assign value_zero = (value_ff[VALUE_W-1:CHUNK_W] == '0) && (step_quot == '0);

   // sequencer
   always_comb begin
      st_in       = st_ff;
      value_in    = value_ff;
      chunk_in    = chunk_ff;
      rem_in      = rem_ff;
      count_in    = count_ff;
      emit_idx_in = emit_idx_ff;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in = {req_data.octet_a, req_data.octet_b, req_data.octet_c,
                           req_data.octet_d, req_data.port_number};
               chunk_in = TOP_CHUNK;
               rem_in   = '0;
               count_in = '0;
               st_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            case (chunk_ff)
               2'd2:    value_in[3*CHUNK_W-1:2*CHUNK_W] = step_quot;
               2'd1:    value_in[2*CHUNK_W-1:CHUNK_W]   = step_quot;
               default: value_in[CHUNK_W-1:0]           = step_quot;
            endcase
            if (chunk_ff != '0) begin
               rem_in   = step_rem;
               chunk_in = chunk_ff - 1'b1;
            end else begin
               rem_in   = '0;
               chunk_in = TOP_CHUNK;
               count_in = count_ff + 1'b1;
               if (value_zero || (count_ff == COUNT_W'(MAX_DIGITS - 1))) begin
                  emit_idx_in = count_ff;
                  st_in       = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (emit_idx_ff == '0) begin
               st_in = ST_IDLE;
            end else begin
               emit_idx_in = emit_idx_ff - 1'b1;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         count_ff <= '0;
      end else begin
         st_ff    <= st_in;
         count_ff <= count_in;
      end
      value_ff    <= value_in;
      chunk_ff    <= chunk_in;
      rem_ff      <= rem_in;
      emit_idx_ff <= emit_idx_in;
   end

   // digit store, least significant digit first
   always_ff @(posedge clock) begin
      if (digit_done) begin
         store_ff[count_ff[IDX_W-1:0]] <= step_rem;
      end
   end

   // letter output, most significant digit first
   assign emit_digit           = store_ff[emit_idx_ff[IDX_W-1:0]];
   assign rsp_strobe           = (st_ff == ST_EMIT);
   assign rsp_data.letter      = LETTER_BASE + 7'(emit_digit);
   assign rsp_data.last_letter = (emit_idx_ff == '0);

`ifndef SYNTHESIS
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("letter strobed while not busy");

   a_accept_div: assert property (@(posedge clock) disable iff (reset)
      accept |=> (st_ff == ST_DIV) && (chunk_ff == TOP_CHUNK) && (count_ff == '0))
      else $error("accepted item did not start extraction");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_letter) |=> !busy)
      else $error("block still busy after the last letter");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      digit_done |-> (step_rem < DIGIT_W'(RADIX)))
      else $error("digit out of base-26 range");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (emit_idx_ff < count_ff) && (count_ff <= COUNT_W'(MAX_DIGITS)))
      else $error("letter index beyond stored digits");
`endif

endmodule

/* sv/ep26_div_step.sv */
`timescale 1ns / 1ps
// ep26_div_step: one long-division step, {remainder, 16-bit chunk} divided by 26
// depends on ep26_pkg

module ep26_div_step (
   input  logic [ep26_pkg::DIGIT_W-1:0] rem_in,
   input  logic [ep26_pkg::CHUNK_W-1:0] chunk_in,
   output logic [ep26_pkg::CHUNK_W-1:0] quot_out,
   output logic [ep26_pkg::DIGIT_W-1:0] rem_out
);
   import ep26_pkg::*;

   localparam int PROD_W = DIV_IN_W + RECIP_W;

   logic [DIV_IN_W-1:0] dividend;
   logic [PROD_W-1:0]   product;
   logic [DIV_IN_W-1:0] q_est;
   logic [DIV_IN_W-1:0] q_times_radix;
   logic [DIV_IN_W-1:0] rem_raw;
   logic                fix_up;

   // reciprocal multiply for the quotient estimate
   assign dividend = {rem_in, chunk_in};
   assign product  = PROD_W'(dividend) * PROD_W'(RECIP);
   assign q_est    = DIV_IN_W'(product >> RECIP_SHIFT);

   // q * 26 as shifts and adds: 16q + 8q + 2q
   assign q_times_radix = (q_est << 4) + (q_est << 3) + (q_est << 1);
   assign rem_raw       = dividend - q_times_radix;

   // guard correction, one compare and subtract
   assign fix_up   = (rem_raw >= DIV_IN_W'(RADIX));
   assign quot_out = CHUNK_W'(q_est) + CHUNK_W'(fix_up);
   assign rem_out  = fix_up ? DIGIT_W'(rem_raw - DIV_IN_W'(RADIX)) : DIGIT_W'(rem_raw);

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking testbench for endpoint_to_base26_letters, with a scoreboard
// that predicts the base-26 letters of each endpoint and checks them in order
// depends on ep26_pkg and the endpoint_to_base26_letters rtl

module tb_top;
   import ep26_pkg::*;

   // holds the letters still owed by the block, oldest first
   class letter_scoreboard;
      rsp_type     expected_letters[$];
      int unsigned fail_count;

      // one line per mismatch
      task report_mismatch(string what);
         fail_count++;
         $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      // divide the packed endpoint by 26 and queue its letters, most significant first
      function void note_endpoint(req_type item);
         logic [47:0] value;
         logic [4:0]  digits[MAX_DIGITS];
         int          n;
         rsp_type     one_letter;
         value = {item.octet_a, item.octet_b, item.octet_c, item.octet_d, item.port_number};
         n = 0;
         if (value == 48'd0) begin
            digits[0] = 5'd0;
            n = 1;
         end else begin
            while (value != 48'd0 && n < MAX_DIGITS) begin
               digits[n] = 5'(value % 48'd26);
               value = value / 48'd26;
               n++;
            end
         end
         for (int k = n - 1; k >= 0; k--) begin
            one_letter.letter      = LETTER_BASE + 7'(digits[k]);
            one_letter.last_letter = (k == 0);
            expected_letters.push_back(one_letter);
         end
      endfunction

      // compare one strobed letter with the oldest expectation
      task check_letter(rsp_type got);
         rsp_type want;
         if (expected_letters.size() == 0) begin
            report_mismatch($sformatf("letter %0d with nothing expected", got.letter));
         end else begin
            want = expected_letters.pop_front();
            if (got.letter !== want.letter)
               report_mismatch($sformatf("letter %0d, expected %0d", got.letter, want.letter));
            if (got.last_letter !== want.last_letter)
               report_mismatch($sformatf("last_letter %b, expected %b on letter %0d",
                                         got.last_letter, want.last_letter, want.letter));
         end
      endtask

      function int unsigned pending();
         return expected_letters.size();
      endfunction
   endclass

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 64;
   localparam int unsigned RANDOM_ITEMS = 370;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_data   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   letter_scoreboard scoreboard = new();
   int unsigned      cycle_count = 0;

   endpoint_to_base26_letters i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // 4 ns clock
   always #2 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // note accepted items and check strobed letters
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            scoreboard.note_endpoint(req_data);
         if (rsp_strobe)
            scoreboard.check_letter(rsp_data);
      end
   end

   function automatic logic [47:0] power_of_26(int unsigned k);
      logic [47:0] p;
      p = 48'd1;
      repeat (k) p = p * 48'd26;
      return p;
   endfunction

   // random endpoint, weighted towards boundaries and short codes
   function automatic logic [47:0] random_endpoint();
      logic [63:0] raw;
      logic [47:0] p;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return raw[47:0];
         4: return {32'd0, raw[15:0]};
         5: begin
            p = power_of_26($urandom_range(0, 10));
            return p + 48'($urandom_range(0, 2)) - 48'd1;
         end
         6: return {($urandom_range(0, 1) ? 8'hFF : 8'h00), ($urandom_range(0, 1) ? 8'hFF : 8'h00),
                    ($urandom_range(0, 1) ? 8'hFF : 8'h00), ($urandom_range(0, 1) ? 8'hFF : 8'h00),
                    ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
         7: return 48'd1 << $urandom_range(0, 47);
         8: return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 300));
         default: return {1'b1, raw[46:0]};
      endcase
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap(bit allow_idle);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!allow_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // present one item and hold it until the block takes it
   task automatic send_endpoint(logic [47:0] value);
      start    <= 1'b1;
      req_data <= req_type'(value);
      do @(posedge clock); while (busy);
   endtask

   // drop start for a while, with junk on the data lines
   task automatic idle_for(int unsigned cycles);
      start    <= 1'b0;
      req_data <= req_type'(48'({$urandom, $urandom}));
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      logic [47:0] directed_values[$];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero, small values, digit boundaries, field extremes and high octets
      directed_values = '{48'd0, 48'd1, 48'd25, 48'd26, 48'd27, 48'd675, 48'd676,
                          48'h0000_0000_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFF00_0000_0000,
                          48'h00FF_0000_0000, 48'h0000_FF00_0000, 48'h0000_00FF_0000,
                          48'h8000_0000_0000, 48'h8080_8080_0000, 48'h0000_0001_0000,
                          power_of_26(10) - 48'd1, power_of_26(10), power_of_26(10) + 48'd1,
                          power_of_26(5), 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555};
      foreach (directed_values[i]) begin
         int unsigned gap;
         send_endpoint(directed_values[i]);
         gap = pick_gap(1'b1);
         if (gap != 0) idle_for(gap);
      end

      // random items, with stretches where start never drops
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         int unsigned gap;
         send_endpoint(random_endpoint());
         gap = pick_gap((i / 40) % 3 != 1);
         if (gap != 0) idle_for(gap);
      end
      start <= 1'b0;

      // let the last letters out, then watch for stray ones
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.pending() != 0)
         scoreboard.report_mismatch("letters still expected at the end");

      if (scoreboard.fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
